[hdl/rmsw_pkg.sv]
// Shared constants and types for the RMSSD window estimator.
// No dependencies; the interfaces, the top level, the squarer and the square root import it.

package rmsw_pkg;

  localparam int RR_W            = 12;       // interval and result width
  localparam int SQ_W            = 2 * RR_W; // width of one squared difference
  localparam int ROOT_W          = 12;       // root of a SQ_W-bit radicand
  localparam int MIN_HELD        = 3;        // intervals needed for a real estimate
  localparam int DEF_WINDOW      = 20;
  localparam logic [RR_W-1:0] DEF_RMSSD_RESET = 12'd80;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_PREV,
    ST_RD_OLD,
    ST_RD_NEXT,
    ST_WRITE,
    ST_SQ_ADD,
    ST_SQ_SUB,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } rmsw_state_t;

endpackage

[hdl/rmsw_ifs.sv]
// Valid/ready channel interfaces for the interval input and the result output.
// Depends on rmsw_pkg for the field widths.

interface rmsw_rr_if import rmsw_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RR_W-1:0] rr_ms;

  modport source (output valid, output rr_ms, input ready);
  modport sink   (input valid, input rr_ms, output ready);
endinterface

interface rmsw_res_if import rmsw_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RR_W-1:0] rmssd_ms;
  logic            window_short;

  modport source (output valid, output rmssd_ms, output window_short, input ready);
  modport sink   (input valid, input rmssd_ms, input window_short, output ready);
endinterface

[hdl/rmssd_window_estimator.sv]
// Top level of the RMSSD window estimator: sequencer, interval ring and output register.
// Depends on rmsw_pkg, rmsw_ifs, rmsw_ram, rmsw_sqr, rmsw_div and rmsw_sqrt.
//
// Usage:
// The interval channel carries one beat-to-beat interval (rr_ms, milliseconds) per beat.
// The result channel returns exactly one beat per interval: rmssd_ms, the floored root
// mean square of successive differences over the last WINDOW intervals in arrival order,
// and window_short, which is set when fewer than three intervals are held and the
// default_rmssd register value is reported instead. cfg_we/cfg_data write that register.
//
// Timing: an interval is taken only while the sequencer is idle. It reads the ring at the
// write pointer and on either side of it and writes the new interval, then the running
// sum of squares is updated incrementally with up to two bit-serial squarings. Unless
// the window is short, the sum is divided by the count minus one in a restoring divider
// and rooted; the result is then loaded into the output register. A new interval is
// taken only once the sequencer has returned to idle after that load. The divider is the
// longest single step.
//
// Reset clears the ring pointer, the fill count, the sum and the output valid flag and
// loads default_rmssd with 80; the window starts empty. The finished result waits in an
// output register, so a new interval is taken while the receiver stalls; the sequencer
// holds its next result until that register has been emptied.

module rmssd_window_estimator import rmsw_pkg::*; #(
  parameter int WINDOW = DEF_WINDOW
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [RR_W-1:0] cfg_data,
  rmsw_rr_if.sink         interval,
  rmsw_res_if.source      result
);

  localparam int PTR_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  // Each squared difference is below 2^SQ_W and at most WINDOW-1 of them are summed.
  localparam int SUM_W = SQ_W + $clog2(WINDOW);

  rmsw_state_t state, state_next;

  logic [RR_W-1:0]  default_rmssd;
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] wp_dec;
  logic [PTR_W-1:0] wp_inc;
  logic [CNT_W-1:0] fill;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic [RR_W-1:0]  rr_q;
  logic [RR_W-1:0]  prev_val;
  logic [RR_W-1:0]  old0;
  logic [RR_W-1:0]  old1;
  logic             evict;
  logic             short_win;

  logic             ram_we;
  logic [PTR_W-1:0] ram_raddr;
  logic [RR_W-1:0]  ram_rdata;

  logic             sq_start;
  logic [RR_W-1:0]  sq_operand;
  logic             sq_done;
  logic [SQ_W-1:0]  sq_product;

  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] div_quotient;

  logic             sqrt_start;
  logic             sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;

  logic             accept;
  logic             load_out;
  logic             out_valid;
  logic [RR_W-1:0]  out_rmssd;
  logic             out_short;

  assign accept    = interval.valid && interval.ready;
  assign wp_dec    = (wp == '0) ? PTR_W'(WINDOW - 1) : wp - PTR_W'(1);
  assign wp_inc    = (wp == PTR_W'(WINDOW - 1)) ? '0 : wp + PTR_W'(1);
  assign short_win = (fill < CNT_W'(MIN_HELD));

  // Ring of the most recent intervals; entries may be read before being written, but only written values are used.
  rmsw_ram #(
    .WIDTH (RR_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (rr_q),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rmsw_sqr u_sqr (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .operand (sq_operand),
    .done    (sq_done),
    .product (sq_product)
  );

  rmsw_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (fill - CNT_W'(1)),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // The mean of the squares is below 2^SQ_W, so only the low quotient bits matter.
  rmsw_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (div_quotient[2*ROOT_W-1:0]),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer. The sum of squares is kept up to date incrementally: the newest
  // difference is added, and once the window is full the difference between the
  // evicted interval and its successor is removed.
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_raddr  = wp;
    sq_start   = 1'b0;
    sq_operand = (rr_q >= prev_val) ? rr_q - prev_val : prev_val - rr_q;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    load_out   = 1'b0;
    sum_next   = sum;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_RD_PREV;
        end
      end
      ST_RD_PREV: begin
        ram_raddr  = wp_dec;
        state_next = ST_RD_OLD;
      end
      ST_RD_OLD: begin
        ram_raddr  = wp;
        state_next = ST_RD_NEXT;
      end
      ST_RD_NEXT: begin
        ram_raddr  = wp_inc;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        ram_we = 1'b1;
        if (fill != '0) begin
          sq_start   = 1'b1;
          state_next = ST_SQ_ADD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SQ_ADD: begin
        sq_operand = (old1 >= old0) ? old1 - old0 : old0 - old1;
        if (sq_done) begin
          sum_next = sum + SUM_W'(sq_product);
          if (evict) begin
            sq_start   = 1'b1;
            state_next = ST_SQ_SUB;
          end else if (short_win) begin
            state_next = ST_DONE;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_SQ_SUB: begin
        if (sq_done) begin
          sum_next   = sum - SUM_W'(sq_product);
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      default_rmssd <= DEF_RMSSD_RESET;
      wp            <= '0;
      fill          <= '0;
      sum           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        default_rmssd <= cfg_data;
      end
      sum <= sum_next;
      if (state == ST_WRITE) begin
        wp <= wp_inc;
        if (fill != CNT_W'(WINDOW)) begin
          fill <= fill + CNT_W'(1);
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers. Read data arrives in the cycle after its address.
  always_ff @(posedge clk) begin
    if (accept) begin
      rr_q <= interval.rr_ms;
    end
    if (state == ST_RD_OLD) begin
      prev_val <= ram_rdata;
    end
    if (state == ST_RD_NEXT) begin
      old0 <= ram_rdata;
    end
    if (state == ST_WRITE) begin
      old1  <= ram_rdata;
      evict <= (fill == CNT_W'(WINDOW));
    end
    if (load_out) begin
      out_rmssd <= short_win ? default_rmssd : sqrt_root;
      out_short <= short_win;
    end
  end

  assign interval.ready      = (state == ST_IDLE);
  assign result.valid        = out_valid;
  assign result.rmssd_ms     = out_rmssd;
  assign result.window_short = out_short;

endmodule

[hdl/rmsw_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.

module rmsw_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/rmsw_sqr.sv]
// Bit-serial squarer: one operand bit per cycle, most significant bit first.
// Depends on rmsw_pkg for the operand and product widths.

module rmsw_sqr import rmsw_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [RR_W-1:0] operand,
  output logic            done,
  output logic [SQ_W-1:0] product
);

  localparam int CNT_W = $clog2(RR_W + 1);

  logic [RR_W-1:0]  mcand;
  logic [RR_W-1:0]  mbits;
  logic [CNT_W-1:0] cnt;
  logic             running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == CNT_W'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(RR_W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  // Shift-and-add, doubling the partial product before each new bit.
  always_ff @(posedge clk) begin
    if (start) begin
      mcand   <= operand;
      mbits   <= operand;
      product <= '0;
    end else if (running) begin
      product <= {product[SQ_W-2:0], 1'b0}
                 + (mbits[RR_W-1] ? SQ_W'(mcand) : SQ_W'(0));
      mbits   <= {mbits[RR_W-2:0], 1'b0};
    end
  end

endmodule

[hdl/rmsw_div.sv]
// Restoring divider producing one quotient bit per cycle.
// Depends on nothing outside its parameters.

module rmsw_div #(
  parameter int DVD_W = 29,
  parameter int DVS_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] shreg;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial    = {rem, shreg[DVD_W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign ge       = (trial >= {1'b0, dvs});
  assign quotient = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == CNT_W'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(DVD_W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  // Dividend bits leave at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      dvs   <= divisor;
    end else if (running) begin
      shreg <= {shreg[DVD_W-2:0], ge};
      rem   <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

endmodule

[hdl/rmsw_sqrt.sv]
// Digit-by-digit integer square root, two radicand bits and one root bit per cycle.
// Depends on rmsw_pkg for the root width.

module rmsw_sqrt import rmsw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2*ROOT_W-1:0] radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] shreg;
  logic [ROOT_W:0]     rem;
  logic [ROOT_W+2:0]   shifted;
  logic [ROOT_W+2:0]   trial;
  logic                ge;
  logic [CNT_W-1:0]    cnt;
  logic                running;

  assign shifted = {rem, shreg[2*ROOT_W-1 -: 2]};
  assign trial   = {1'b0, root, 2'b01};
  assign ge      = (shifted >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == CNT_W'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(ROOT_W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  // The remainder never exceeds twice the partial root, so ROOT_W+1 bits hold it.
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= radicand;
      rem   <= '0;
      root  <= '0;
    end else if (running) begin
      shreg <= {shreg[2*ROOT_W-3:0], 2'b00};
      if (ge) begin
        rem  <= (ROOT_W+1)'(shifted - trial);
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[ROOT_W:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule
